// ----- hw/rtl/pvbs_pkg.sv -----
// Shared types, codes and constants for the protobuf value byte serializer.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package pvbs_pkg;

  localparam int unsigned PosW = 17;
  localparam int unsigned ValW = 64;
  localparam int unsigned CntW = 4;

  localparam logic [PosW-1:0] MaxCapacity = 17'd65536;
  localparam logic [PosW-1:0] CapReset    = 17'd65536;
  localparam logic [CntW-1:0] MaxVarint32Size = 4'd5;
  localparam logic [CntW-1:0] MaxVarint64Size = 4'd10;
  localparam logic [7:0] GroupMask = 8'h7f;
  localparam logic [7:0] ContBit   = 8'h80;

  localparam logic [3:0] OP_UVAR32 = 4'd0;
  localparam logic [3:0] OP_INT32  = 4'd1;
  localparam logic [3:0] OP_VAR64  = 4'd2;
  localparam logic [3:0] OP_FIX32  = 4'd3;
  localparam logic [3:0] OP_FIX64  = 4'd4;
  localparam logic [3:0] OP_BOOL   = 4'd5;
  localparam logic [3:0] OP_RAW    = 4'd6;
  localparam logic [3:0] OP_RESET  = 4'd7;
  localparam logic [3:0] OP_SEEK   = 4'd8;
  localparam logic [3:0] OP_SETPOS = 4'd9;

  typedef logic [PosW-1:0] pos_t;

  typedef enum logic [1:0] {
    ST_BYTE    = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_POS     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    EM_VARINT,
    EM_FIX32,
    EM_FIX64,
    EM_SINGLE
  } emit_mode_e;

  typedef enum logic [2:0] {
    POS_HOLD,
    POS_CLEAR,
    POS_LOAD,
    POS_ADD,
    POS_INC
  } pos_cmd_e;

  typedef enum logic [1:0] {
    K_ENC,
    K_RST,
    K_SEEK,
    K_SET
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_EMIT,
    S_RESP
  } state_e;

  typedef struct packed {
    pos_cmd_e        cmd;
    logic [ValW-1:0] need;
  } pos_ctl_t;

  typedef struct packed {
    pos_t pos;
    pos_t pos_sum;
    logic fit;
    logic set_ok;
  } pos_sts_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [3:0] opcode;
  } emit_ctl_t;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic [7:0]      wire_byte;
    logic [CntW-1:0] n_bytes;
  } emit_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pvbs_emit_unit.sv -----
// Operand shift register and byte extractor: one wire byte per step.
// Depends on pvbs_pkg.
`default_nettype none

module pvbs_emit_unit (
  input  wire logic                      clk_i,
  input  wire pvbs_pkg::emit_ctl_t       ctl_i,
  input  wire logic [pvbs_pkg::ValW-1:0] operand_i,
  output      pvbs_pkg::emit_sts_t       sts_o
);
  import pvbs_pkg::*;

  logic [ValW-1:0] sh_q, sh_d;
  emit_mode_e      mode_q, mode_d;
  logic [CntW-1:0] var_len;

  always_comb begin
    sh_d   = sh_q;
    mode_d = mode_q;
    if (ctl_i.load) begin
      unique case (ctl_i.opcode)
        OP_UVAR32: begin
          sh_d   = {32'd0, operand_i[31:0]};
          mode_d = EM_VARINT;
        end
        OP_INT32: begin
          sh_d   = {{32{operand_i[31]}}, operand_i[31:0]};
          mode_d = EM_VARINT;
        end
        OP_VAR64: begin
          sh_d   = operand_i;
          mode_d = EM_VARINT;
        end
        OP_FIX32: begin
          sh_d   = operand_i;
          mode_d = EM_FIX32;
        end
        OP_FIX64: begin
          sh_d   = operand_i;
          mode_d = EM_FIX64;
        end
        OP_BOOL: begin
          sh_d   = {63'd0, |operand_i};
          mode_d = EM_SINGLE;
        end
        OP_RAW: begin
          sh_d   = {56'd0, operand_i[7:0]};
          mode_d = EM_SINGLE;
        end
        default: begin
          sh_d   = operand_i;
          mode_d = EM_SINGLE;
        end
      endcase
    end else if (ctl_i.step) begin
      sh_d = (mode_q == EM_VARINT) ? (sh_q >> 7) : (sh_q >> 8);
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    mode_q <= mode_d;
  end

  always_comb begin
    var_len = 4'd1;
    for (int k = 1; k < int'(MaxVarint64Size); k++) begin
      if (|(sh_q >> (7 * k))) var_len = CntW'(k + 1);
    end
  end

  always_comb begin
    sts_o.value = sh_q;
    unique case (mode_q)
      EM_VARINT: begin
        sts_o.wire_byte = {1'b0, sh_q[6:0] & GroupMask[6:0]} |
                          ((|sh_q[63:7]) ? ContBit : 8'h00);
        sts_o.n_bytes   = var_len;
      end
      EM_FIX32: begin
        sts_o.wire_byte = sh_q[7:0];
        sts_o.n_bytes   = 4'd4;
      end
      EM_FIX64: begin
        sts_o.wire_byte = sh_q[7:0];
        sts_o.n_bytes   = 4'd8;
      end
      default: begin
        sts_o.wire_byte = sh_q[7:0];
        sts_o.n_bytes   = 4'd1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pvbs_pos_unit.sv -----
// Write position and capacity registers with the shared position adder and room compare.
// Depends on pvbs_pkg.
`default_nettype none

module pvbs_pos_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire pvbs_pkg::pos_t      cfg_wdata_i,
  input  wire pvbs_pkg::pos_ctl_t  ctl_i,
  output      pvbs_pkg::pos_sts_t  sts_o
);
  import pvbs_pkg::*;

  pos_t        cap_q, pos_q, pos_d;
  pos_t        cap_eff, addend, sum;
  logic [PosW:0] room;
  logic        need_small;

  assign cap_eff    = (cap_q > MaxCapacity) ? MaxCapacity : cap_q;
  assign room       = {1'b0, cap_eff} - {1'b0, pos_q};
  assign need_small = ~|ctl_i.need[ValW-1:PosW];
  assign addend     = (ctl_i.cmd == POS_INC) ? pos_t'(1) : ctl_i.need[PosW-1:0];
  assign sum        = pos_q + addend;

  always_comb begin
    unique case (ctl_i.cmd)
      POS_CLEAR:        pos_d = '0;
      POS_LOAD:         pos_d = ctl_i.need[PosW-1:0];
      POS_ADD, POS_INC: pos_d = sum;
      default:          pos_d = pos_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
      pos_q <= '0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      pos_q <= pos_d;
    end
  end

  assign sts_o.pos     = pos_q;
  assign sts_o.pos_sum = sum;
  assign sts_o.fit     = !room[PosW] && need_small && (ctl_i.need[PosW-1:0] <= room[PosW-1:0]);
  assign sts_o.set_ok  = need_small && (ctl_i.need[PosW-1:0] <= cap_eff);

endmodule

`default_nettype wire

// ----- hw/rtl/pvbs_ctrl.sv -----
// Sequencer: accepts a word, checks room, steps the emit unit and fills the output register.
// Depends on pvbs_pkg.
`default_nettype none

module pvbs_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire logic [3:0]           in_opcode_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      pvbs_pkg::status_e    out_status_o,
  output      logic [7:0]           out_byte_o,
  output      logic [15:0]          out_addr_o,
  output      pvbs_pkg::pos_t       out_newpos_o,
  output      logic                 out_last_o,
  output      pvbs_pkg::emit_ctl_t  emit_ctl_o,
  input  wire pvbs_pkg::emit_sts_t  emit_sts_i,
  output      pvbs_pkg::pos_ctl_t   pos_ctl_o,
  input  wire pvbs_pkg::pos_sts_t   pos_sts_i
);
  import pvbs_pkg::*;

  state_e          state_q, state_d;
  kind_e           kind_q, kind_d;
  status_e         rstat_q, rstat_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic       ov_q, ov_d;
  status_e    ostat_q, ostat_d;
  logic [7:0] obyte_q, obyte_d;
  logic [15:0] oaddr_q, oaddr_d;
  pos_t       onew_q, onew_d;
  logic       olast_q, olast_d;
  logic       out_free, out_load;

  assign out_free = !ov_q || out_ready_i;

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    rstat_d  = rstat_q;
    cnt_d    = cnt_q;
    ostat_d  = ostat_q;
    obyte_d  = obyte_q;
    oaddr_d  = oaddr_q;
    onew_d   = onew_q;
    olast_d  = olast_q;
    out_load = 1'b0;
    in_ready_o = 1'b0;
    emit_ctl_o.load   = 1'b0;
    emit_ctl_o.step   = 1'b0;
    emit_ctl_o.opcode = in_opcode_i;
    pos_ctl_o.cmd  = POS_HOLD;
    pos_ctl_o.need = emit_sts_i.value;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          priority if (in_opcode_i <= OP_RAW) begin
            kind_d = K_ENC;
          end else if (in_opcode_i == OP_RESET) begin
            kind_d = K_RST;
          end else if (in_opcode_i == OP_SEEK) begin
            kind_d = K_SEEK;
          end else begin
            kind_d = K_SET;
          end
          if (in_opcode_i <= OP_SETPOS) begin
            emit_ctl_o.load = 1'b1;
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        state_d = S_RESP;
        rstat_d = ST_POS;
        unique case (kind_q)
          K_ENC: begin
            pos_ctl_o.need = {{(ValW-CntW){1'b0}}, emit_sts_i.n_bytes};
            cnt_d = emit_sts_i.n_bytes;
            if (pos_sts_i.fit) state_d = S_EMIT;
            else rstat_d = ST_NOSPACE;
          end
          K_RST: pos_ctl_o.cmd = POS_CLEAR;
          K_SEEK: begin
            if (pos_sts_i.fit) pos_ctl_o.cmd = POS_ADD;
            else rstat_d = ST_NOSPACE;
          end
          default: begin
            if (pos_sts_i.set_ok) pos_ctl_o.cmd = POS_LOAD;
            else rstat_d = ST_NOSPACE;
          end
        endcase
      end
      S_EMIT: begin
        if (out_free) begin
          out_load        = 1'b1;
          pos_ctl_o.cmd   = POS_INC;
          emit_ctl_o.step = 1'b1;
          ostat_d = ST_BYTE;
          obyte_d = emit_sts_i.wire_byte;
          oaddr_d = pos_sts_i.pos[15:0];
          onew_d  = pos_sts_i.pos_sum;
          olast_d = (cnt_q == 4'd1);
          cnt_d   = cnt_q - 4'd1;
          if (cnt_q == 4'd1) state_d = S_IDLE;
        end
      end
      default: begin
        if (out_free) begin
          out_load = 1'b1;
          ostat_d = rstat_q;
          obyte_d = '0;
          oaddr_d = pos_sts_i.pos[15:0];
          onew_d  = pos_sts_i.pos;
          olast_d = 1'b1;
          state_d = S_IDLE;
        end
      end
    endcase

    if (out_load) ov_d = 1'b1;
    else if (out_ready_i) ov_d = 1'b0;
    else ov_d = ov_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    rstat_q <= rstat_d;
    cnt_q   <= cnt_d;
    ostat_q <= ostat_d;
    obyte_q <= obyte_d;
    oaddr_q <= oaddr_d;
    onew_q  <= onew_d;
    olast_q <= olast_d;
  end

  assign out_valid_o  = ov_q;
  assign out_status_o = ostat_q;
  assign out_byte_o   = obyte_q;
  assign out_addr_o   = oaddr_q;
  assign out_newpos_o = onew_q;
  assign out_last_o   = olast_q;

endmodule

`default_nettype wire

// ----- hw/rtl/protobuf_value_byte_serializer.sv -----
// Top level of the protobuf value byte serializer.
// Instantiates pvbs_ctrl, pvbs_emit_unit and pvbs_pos_unit; depends on pvbs_pkg.
//
// Usage:
//   Input stream (s_axis_*): one word per opcode; tuser carries the opcode,
//   tdata the 64-bit operand. Opcodes 10..15 are taken and dropped.
//   Output stream (m_axis_*): one word per wire byte, or one status word for
//   position commands and no_space; tlast marks the final word of an input.
//   cfg_we_i/cfg_wdata_i write buffer_capacity; write it only while idle.
// Sequence:
//   An input is latched while idle, then room is checked against the
//   capacity, then the output words follow (1..10 bytes, or 1 status word).
//   The emit shift register and the position adder are stepped as each
//   byte word is loaded into the output register.
// Reset: write position goes to 0, buffer_capacity to 65536, output empty.
// Stall: while m_axis_tready is low the output word holds and the sequencer
//   waits; the next input is taken once the last word sits in the output
//   register.
`default_nettype none

module protobuf_value_byte_serializer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [63:0] operand_value
  input  wire logic [3:0]  s_axis_tuser,   // [3:0] opcode
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [47:0] m_axis_tdata,   // [7:0] data_byte, [23:8] byte_address,
                                           // [40:24] new_position, [47:41] zero
  output      logic [1:0]  m_axis_tuser,   // [1:0] status
  output      logic        m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [16:0] cfg_wdata_i
);
  import pvbs_pkg::*;

  emit_ctl_t  emit_ctl;
  emit_sts_t  emit_sts;
  pos_ctl_t   pos_ctl;
  pos_sts_t   pos_sts;
  status_e    out_status;
  logic [7:0] out_byte;
  logic [15:0] out_addr;
  pos_t       out_newpos;

  pvbs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_opcode_i  (s_axis_tuser),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_byte_o   (out_byte),
    .out_addr_o   (out_addr),
    .out_newpos_o (out_newpos),
    .out_last_o   (m_axis_tlast),
    .emit_ctl_o   (emit_ctl),
    .emit_sts_i   (emit_sts),
    .pos_ctl_o    (pos_ctl),
    .pos_sts_i    (pos_sts)
  );

  pvbs_emit_unit u_emit (
    .clk_i     (clk_i),
    .ctl_i     (emit_ctl),
    .operand_i (s_axis_tdata),
    .sts_o     (emit_sts)
  );

  pvbs_pos_unit u_pos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctl_i       (pos_ctl),
    .sts_o       (pos_sts)
  );

  assign m_axis_tdata = {7'd0, out_newpos, out_addr, out_byte};
  assign m_axis_tuser = out_status;

endmodule

`default_nettype wire

// ----- hw/rtl/pvbs_checker.sv -----
// Port-level checks on the serializer output stream, bound to the top level.
// Depends on pvbs_pkg and protobuf_value_byte_serializer.
`default_nettype none

module pvbs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);
  import pvbs_pkg::*;

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_byte_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_BYTE |->
      m_axis_tdata[40:24] == ({1'b0, m_axis_tdata[23:8]} + 17'd1))
    else $error("byte word new position is not address plus one");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_BYTE |->
      m_axis_tlast && m_axis_tdata[7:0] == 8'd0 &&
      m_axis_tdata[23:8] == m_axis_tdata[39:24])
    else $error("status word malformed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser == ST_BYTE || m_axis_tuser == ST_NOSPACE ||
      m_axis_tuser == ST_POS)
    else $error("undefined status code");

endmodule

bind protobuf_value_byte_serializer pvbs_checker u_pvbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- verif/protobuf_value_byte_serializer_checker.sv -----
// Scoreboard for the protobuf value byte serializer: watches both streams and the
// capacity port, predicts every output word and compares it field by field.
// Depends on pvbs_pkg for opcodes, status codes and capacity constants.
`default_nettype none

module protobuf_value_byte_serializer_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [63:0] operand_value
  input  wire logic [3:0]  s_axis_tuser,   // [3:0] opcode
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [47:0] m_axis_tdata,   // [7:0] data_byte, [23:8] byte_address,
                                           // [40:24] new_position, [47:41] zero
  input  wire logic [1:0]  m_axis_tuser,   // [1:0] status
  input  wire logic        m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [16:0] cfg_wdata_i,
  output int               mismatches,
  output int               outstanding,
  output int               words_in,
  output int               bytes_out,
  output int               nospace_out,
  output int               position_out
);
  import pvbs_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [7:0]  data;
    logic [15:0] addr;
    pos_t        newpos;
    logic        last;
  } wire_word_t;

  wire_word_t  pending_words[$];
  pos_t        write_pos;
  logic [16:0] capacity;

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    words_in     = 0;
    bytes_out    = 0;
    nospace_out  = 0;
    position_out = 0;
  end

  function automatic logic [63:0] usable_room();
    logic [63:0] cap;
    cap = (capacity > MaxCapacity) ? 64'(MaxCapacity) : 64'(capacity);
    return (64'(write_pos) > cap) ? 64'd0 : cap - 64'(write_pos);
  endfunction

  function automatic logic beyond_capacity();
    return capacity > MaxCapacity ? 1'b0 : write_pos > capacity;
  endfunction

  task automatic push_status(input status_e st);
    wire_word_t w;
    w.status = st;
    w.data   = '0;
    w.addr   = write_pos[15:0];
    w.newpos = write_pos;
    w.last   = 1'b1;
    pending_words.push_back(w);
  endtask

  task automatic predict_encoding(input logic [3:0] op, input logic [63:0] v);
    logic [7:0]  wire_bytes [10];
    logic [63:0] acc;
    logic        encode;
    int          n;
    wire_word_t  w;
    n = 0;
    encode = 1'b1;
    acc = v;
    case (op)
      OP_UVAR32, OP_INT32, OP_VAR64: begin
        if (op == OP_UVAR32) acc = {32'd0, v[31:0]};
        if (op == OP_INT32) acc = {{32{v[31]}}, v[31:0]};
        while (acc > 64'(GroupMask)) begin
          wire_bytes[n] = (acc[7:0] & GroupMask) | ContBit;
          n++;
          acc = acc >> 7;
        end
        wire_bytes[n] = acc[7:0];
        n++;
      end
      OP_FIX32, OP_FIX64: begin
        n = (op == OP_FIX32) ? 4 : 8;
        for (int i = 0; i < n; i++) wire_bytes[i] = v[8*i +: 8];
      end
      OP_BOOL: begin
        wire_bytes[0] = (v != 0) ? 8'd1 : 8'd0;
        n = 1;
      end
      OP_RAW: begin
        wire_bytes[0] = v[7:0];
        n = 1;
      end
      OP_RESET: begin
        encode = 1'b0;
        write_pos = '0;
        push_status(ST_POS);
      end
      OP_SEEK: begin
        encode = 1'b0;
        if (beyond_capacity() || v > usable_room()) begin
          push_status(ST_NOSPACE);
        end else begin
          write_pos = write_pos + v[16:0];
          push_status(ST_POS);
        end
      end
      OP_SETPOS: begin
        encode = 1'b0;
        if (v > 64'((capacity > MaxCapacity) ? MaxCapacity : capacity)) begin
          push_status(ST_NOSPACE);
        end else begin
          write_pos = v[16:0];
          push_status(ST_POS);
        end
      end
      default: encode = 1'b0;
    endcase
    if (encode) begin
      if (beyond_capacity() || 64'(n) > usable_room()) begin
        push_status(ST_NOSPACE);
      end else begin
        for (int i = 0; i < n; i++) begin
          w.status = ST_BYTE;
          w.data   = wire_bytes[i];
          w.addr   = write_pos[15:0];
          write_pos = write_pos + 17'd1;
          w.newpos = write_pos;
          w.last   = (i == n - 1);
          pending_words.push_back(w);
        end
      end
    end
  endtask

  task automatic check_word();
    wire_word_t want;
    case (m_axis_tuser)
      ST_BYTE:    bytes_out++;
      ST_NOSPACE: nospace_out++;
      default:    position_out++;
    endcase
    if (pending_words.size() == 0) begin
      $error("output word with nothing pending: status %0d tdata %h", m_axis_tuser,
             m_axis_tdata);
      mismatches++;
    end else begin
      want = pending_words.pop_front();
      if (m_axis_tuser !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
        mismatches++;
      end
      if (m_axis_tdata[7:0] !== want.data) begin
        $error("data_byte: expected %h, got %h", want.data, m_axis_tdata[7:0]);
        mismatches++;
      end
      if (m_axis_tdata[23:8] !== want.addr) begin
        $error("byte_address: expected %0d, got %0d", want.addr, m_axis_tdata[23:8]);
        mismatches++;
      end
      if (m_axis_tdata[40:24] !== want.newpos) begin
        $error("new_position: expected %0d, got %0d", want.newpos, m_axis_tdata[40:24]);
        mismatches++;
      end
      if (m_axis_tlast !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_pos = '0;
      capacity = CapReset;
      pending_words.delete();
      outstanding = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_word();
      if (cfg_we_i) capacity = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        words_in++;
        predict_encoding(s_axis_tuser, s_axis_tdata);
      end
      outstanding = pending_words.size();
    end
  end

endmodule

`default_nettype wire

// ----- verif/protobuf_value_byte_serializer_tb.sv -----
// Testbench top for the protobuf value byte serializer: drives directed and random
// words under several capacities and stall patterns, and gives the verdict.
// Depends on pvbs_pkg, the serializer RTL and protobuf_value_byte_serializer_checker.
`default_nettype none

module protobuf_value_byte_serializer_tb;
  import pvbs_pkg::*;

  localparam logic [3:0] OpFirstUnused = 4'd10;
  localparam logic [3:0] OpLastUnused  = 4'd15;
  localparam int QuietLimit    = 2000;
  localparam int SettleCycles  = 16;
  localparam int HoldOffCycles = 150;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // [63:0] operand_value
  logic [3:0]  s_axis_tuser;   // [3:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [7:0] data_byte, [23:8] byte_address,
                               // [40:24] new_position, [47:41] zero
  logic [1:0]  m_axis_tuser;   // [1:0] status
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic [16:0] cfg_wdata_i;

  int mismatches, outstanding, words_in, bytes_out, nospace_out, position_out;
  int tx_idle_pct, rx_idle_pct, cap_eff, cap_settings, quiet_cycles;
  logic hold_off_req;

  protobuf_value_byte_serializer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  protobuf_value_byte_serializer_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .words_in      (words_in),
    .bytes_out     (bytes_out),
    .nospace_out   (nospace_out),
    .position_out  (position_out)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random backpressure, or one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic offer_word(input logic [3:0] op, input logic [63:0] operand);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= operand;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic wait_for_outputs();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_capacity(input logic [16:0] value);
    wait_for_outputs();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cap_eff = (value > MaxCapacity) ? int'(MaxCapacity) : int'(value);
    cap_settings++;
  endtask

  task automatic run_random(input int count);
    logic [3:0]  op;
    logic [63:0] operand;
    int          sent;
    int          pick;
    int          room;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      operand = {$urandom, $urandom} >> $urandom_range(63);
      if (pick < 72) begin
        op = 4'($urandom_range(OP_RAW, OP_UVAR32));
      end else if (pick < 80) begin
        op = OP_SEEK;
        if ($urandom_range(4) != 0) operand = 64'($urandom_range(24));
      end else if (pick < 90) begin
        op = OP_SETPOS;
        case ($urandom_range(4))
          0:       operand = {$urandom, $urandom};
          1, 2:    operand = 64'($urandom_range(cap_eff));
          default: begin
            room = $urandom_range(12);
            operand = (cap_eff > room) ? 64'(cap_eff - room) : 64'd0;
          end
        endcase
      end else if (pick < 95) begin
        op = OP_RESET;
      end else begin
        op = 4'($urandom_range(OpLastUnused, OpFirstUnused));
      end
      offer_word(op, operand);
      if (op < OpFirstUnused) sent++;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_UVAR32;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    hold_off_req  = 1'b0;
    quiet_cycles  = 0;
    tx_idle_pct   = 20;
    rx_idle_pct   = 53;
    cap_eff       = int'(CapReset);
    cap_settings  = 1;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    offer_word(OP_UVAR32, 64'd0);
    offer_word(OP_UVAR32, 64'hFFFF_FFFF_FFFF_FFFF);
    offer_word(OP_INT32,  64'h0000_0000_8000_0000);
    offer_word(OP_INT32,  64'hFFFF_FFFF_7FFF_FFFF);
    offer_word(OP_VAR64,  64'hFFFF_FFFF_FFFF_FFFF);
    offer_word(OP_VAR64,  64'h80);
    offer_word(OP_FIX32,  64'h0123_4567_89AB_CDEF);
    offer_word(OP_FIX64,  64'h0123_4567_89AB_CDEF);
    offer_word(OP_BOOL,   64'd0);
    offer_word(OP_BOOL,   64'h8000_0000_0000_0000);
    offer_word(OP_RAW,    64'hFFFF_FFFF_FFFF_FFFF);
    offer_word(OpFirstUnused, 64'h5A5A_5A5A_5A5A_5A5A);
    offer_word(OpLastUnused,  64'hA5A5_A5A5_A5A5_A5A5);
    offer_word(OP_SETPOS, 64'd65536);
    offer_word(OP_RAW,    64'h42);
    offer_word(OP_SEEK,   64'd1);
    offer_word(OP_SEEK,   64'd0);
    offer_word(OP_SETPOS, 64'd65537);
    offer_word(OP_SETPOS, 64'hFFFF_FFFF_FFFF_FFFF);
    offer_word(OP_RESET,  64'd0);
    offer_word(OP_SEEK,   64'd65536);
    offer_word(OP_SETPOS, 64'd60000);
    // shrink capacity below the current position
    set_capacity(17'd100);
    offer_word(OP_VAR64,  64'd5);
    offer_word(OP_SEEK,   64'd0);
    offer_word(OP_SETPOS, 64'd50);
    offer_word(OP_RESET,  64'd0);

    set_capacity(17'h1FFFF);
    run_random(130);
    set_capacity(17'd0);
    run_random(15);

    // long receiver hold-off with the sender pushing, then drain
    set_capacity(17'd200);
    tx_idle_pct = 0;
    hold_off_req = 1'b1;
    run_random(30);
    wait_for_outputs();

    tx_idle_pct = 53;
    rx_idle_pct = 20;
    set_capacity(17'd64);
    run_random(120);
    set_capacity(17'd1);
    run_random(15);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_capacity(17'd65535);
    run_random(140);
    wait_for_outputs();

    $display("Run covered %0d input words and %0d output words: %0d bytes, %0d no_space,",
             words_in, bytes_out + nospace_out + position_out, bytes_out, nospace_out);
    $display("%0d position updates, across %0d capacity settings and three stall patterns.",
             position_out, cap_settings);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
